// ===== rtl/ini_stream_tokenizer_assert.svh =====
// assertion macros for the tokenizer checker
`ifndef INI_STREAM_TOKENIZER_ASSERT_SVH
`define INI_STREAM_TOKENIZER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define IST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// next-cycle implication, sampled on the rising clock edge outside reset
`define IST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

// ===== rtl/ist_pkg.sv =====
// shared constants and types of the ini stream tokenizer
package ist_pkg;

  // scan modes
  localparam logic [1:0] ModeBetween = 2'd0;
  localparam logic [1:0] ModeComment = 2'd1;
  localparam logic [1:0] ModeQuoted  = 2'd2;
  localparam logic [1:0] ModeBare    = 2'd3;

  // token kinds
  localparam logic [2:0] TkNewline = 3'd0;
  localparam logic [2:0] TkEqual   = 3'd1;
  localparam logic [2:0] TkLbrack  = 3'd2;
  localparam logic [2:0] TkRbrack  = 3'd3;
  localparam logic [2:0] TkSbegin  = 3'd4;
  localparam logic [2:0] TkSchar   = 3'd5;
  localparam logic [2:0] TkSend    = 3'd6;
  localparam logic [2:0] TkEnd     = 3'd7;

  // characters with a meaning of their own
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChEqual   = 8'h3D;
  localparam logic [7:0] ChLbrack  = 8'h5B;
  localparam logic [7:0] ChRbrack  = 8'h5D;
  localparam logic [7:0] ChQuote   = 8'h22;

  // result queue sizing
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  // one result item
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic       last;
  } result_t;

  // everything one input byte produces
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
    logic [1:0] mode;
  } step_t;

  function automatic result_t mk_result(logic [2:0] kind, logic [7:0] ch);
    result_t r;
    r.kind = kind;
    r.ch   = (kind == TkSchar) ? ch : 8'h00;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/ist_lexer_step.sv =====
// next scan mode and up to two results for one input byte
module ist_lexer_step import ist_pkg::*; (
  input  logic [1:0] mode_i,
  input  logic [7:0] input_byte_i,
  input  logic       end_of_input_i,
  output step_t      step_o
);

  logic [1:0] b_mode;
  logic [1:0] b_n;
  result_t    b_r0;
  result_t    b_r1;
  logic       ends_bare;
  step_t      s;

  // byte handled as if between tokens
  always_comb begin
    b_mode = ModeBetween;
    b_n    = 2'd0;
    b_r0   = mk_result(TkNewline, 8'h00);
    b_r1   = mk_result(TkNewline, 8'h00);
    unique case (input_byte_i) inside
      ChSpace, ChTab: begin
        b_mode = ModeBetween;
      end
      ChSemi, ChHash: begin
        b_mode = ModeComment;
      end
      ChNewline: begin
        b_n  = 2'd1;
        b_r0 = mk_result(TkNewline, 8'h00);
      end
      ChEqual: begin
        b_n  = 2'd1;
        b_r0 = mk_result(TkEqual, 8'h00);
      end
      ChLbrack: begin
        b_n  = 2'd1;
        b_r0 = mk_result(TkLbrack, 8'h00);
      end
      ChRbrack: begin
        b_n  = 2'd1;
        b_r0 = mk_result(TkRbrack, 8'h00);
      end
      ChQuote: begin
        b_mode = ModeQuoted;
        b_n    = 2'd1;
        b_r0   = mk_result(TkSbegin, 8'h00);
      end
      default: begin
        b_mode = ModeBare;
        b_n    = 2'd2;
        b_r0   = mk_result(TkSbegin, 8'h00);
        b_r1   = mk_result(TkSchar, input_byte_i);
      end
    endcase
  end

  // bytes that close a bare string
  assign ends_bare = (input_byte_i == ChNewline) || (input_byte_i == ChEqual) ||
                     (input_byte_i == ChLbrack)  || (input_byte_i == ChRbrack) ||
                     (input_byte_i == ChQuote)   || (input_byte_i == ChSemi)   ||
                     (input_byte_i == ChHash);

  // mode dispatch
  always_comb begin
    s.n    = 2'd0;
    s.r0   = mk_result(TkNewline, 8'h00);
    s.r1   = mk_result(TkNewline, 8'h00);
    s.mode = mode_i;
    if (end_of_input_i) begin
      s.mode = ModeBetween;
      if (mode_i == ModeQuoted || mode_i == ModeBare) begin
        s.n  = 2'd2;
        s.r0 = mk_result(TkSend, 8'h00);
        s.r1 = mk_result(TkEnd, 8'h00);
      end else begin
        s.n  = 2'd1;
        s.r0 = mk_result(TkEnd, 8'h00);
      end
    end else begin
      unique case (mode_i)
        ModeComment: begin
          if (input_byte_i == ChNewline) begin
            s.mode = ModeBetween;
            s.n    = 2'd1;
            s.r0   = mk_result(TkNewline, 8'h00);
          end
        end
        ModeQuoted: begin
          s.n = 2'd1;
          if (input_byte_i == ChQuote || input_byte_i == ChNewline) begin
            s.mode = ModeBetween;
            s.r0   = mk_result(TkSend, 8'h00);
          end else begin
            s.r0 = mk_result(TkSchar, input_byte_i);
          end
        end
        ModeBare: begin
          if (ends_bare) begin
            // closing byte gives at most one token of its own
            s.mode = b_mode;
            s.n    = b_n + 2'd1;
            s.r0   = mk_result(TkSend, 8'h00);
            s.r1   = b_r0;
          end else begin
            s.n  = 2'd1;
            s.r0 = mk_result(TkSchar, input_byte_i);
          end
        end
        default: begin
          s.mode = b_mode;
          s.n    = b_n;
          s.r0   = b_r0;
          s.r1   = b_r1;
        end
      endcase
    end
    // mark the final result of the byte
    s.r0.last = (s.n == 2'd1);
    s.r1.last = 1'b1;
  end

  assign step_o = s;

endmodule

// ===== rtl/ini_stream_tokenizer.sv =====
// top level of the ini stream tokenizer: scan mode register and result queue
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+--------------------------------------
//  in       | sink      | in_valid_i / in_stall_o  | input_byte_i, end_of_input_i
//  out      | source    | out_valid_o / out_stall_i| token_kind_o, string_char_o, last_of_run_o
//
// one input byte is taken per unstalled cycle; its results land in a four-entry queue the next edge
// results leave one per unstalled cycle; a byte that gives two results makes two transfers
// in_stall_o rises while fewer than two queue entries are free, and depends on no input
// reset empties the queue and returns the scan mode to between tokens
module ini_stream_tokenizer import ist_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] input_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] token_kind_o,
  output logic [7:0] string_char_o,
  output logic       last_of_run_o
);

  logic [1:0]    mode_q, mode_d;
  step_t         step;
  result_t       mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic [1:0]    wr_n;
  logic          in_xfer, out_xfer;
  result_t       head;

  // per-byte decode
  ist_lexer_step u_step (
    .mode_i         (mode_q),
    .input_byte_i   (input_byte_i),
    .end_of_input_i (end_of_input_i),
    .step_o         (step)
  );

  // handshakes
  assign in_stall_o = (count_q > CntW'(QueueDepth - 2));
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != '0);
  assign out_xfer   = out_valid_o && !out_stall_i;
  assign wr_n       = in_xfer ? step.n : 2'd0;
  assign mode_d     = in_xfer ? step.mode : mode_q;

  // scan mode and queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeBetween;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      mode_q   <= mode_d;
      wr_ptr_q <= wr_ptr_q + PtrW'(wr_n);
      rd_ptr_q <= rd_ptr_q + PtrW'(out_xfer);
      count_q  <= count_q + CntW'(wr_n) - CntW'(out_xfer);
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr_n != 2'd0) begin
      mem_q[wr_ptr_q] <= step.r0;
    end
    if (wr_n == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= step.r1;
    end
  end

  // head of queue drives the result transfer
  assign head          = mem_q[rd_ptr_q];
  assign token_kind_o  = head.kind;
  assign string_char_o = head.ch;
  assign last_of_run_o = head.last;

endmodule

// ===== rtl/ist_checker.sv =====
// port-level checks of the tokenizer, bound to the top level
`include "ini_stream_tokenizer_assert.svh"

module ist_checker import ist_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       end_of_input_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] token_kind_o,
  input logic [7:0] string_char_o,
  input logic       last_of_run_o
);

  logic [11:0] out_word;
  logic        is_punct;
  logic        eoi_xfer;

  // result payload as one word, punctuation and end kinds, end-of-input transfer
  assign out_word = {token_kind_o, string_char_o, last_of_run_o};
  assign is_punct = (token_kind_o == TkNewline) || (token_kind_o == TkEqual) ||
                    (token_kind_o == TkLbrack)  || (token_kind_o == TkRbrack) ||
                    (token_kind_o == TkEnd);
  assign eoi_xfer = in_valid_i && !in_stall_o && end_of_input_i;

  // a stalled result transfer keeps its payload
  `IST_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word))

  // only string characters carry a character
  `IST_ASSERT_IMP(a_char_zero, out_valid_o && token_kind_o != TkSchar, string_char_o == 8'h00)

  // punctuation and end tokens always close their byte's results
  `IST_ASSERT_IMP(a_punct_last, out_valid_o && is_punct, last_of_run_o)

  // an end-of-input transfer always leaves a result waiting
  `IST_ASSERT_NXT(a_eoi_result, eoi_xfer, out_valid_o)

endmodule

bind ini_stream_tokenizer ist_checker u_ist_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for the ini stream tokenizer: token scoreboard, byte driver, token sink
module testbench;
  import ist_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned RandomRuns = 610;

  // follows the scan mode and holds the tokens the block still owes
  class token_scoreboard;
    result_t     owed[$];
    result_t     step_run[$];
    logic [1:0]  mode;
    int unsigned fails;
    int unsigned checked;

    function new();
      mode    = ModeBetween;
      fails   = 0;
      checked = 0;
    endfunction

    function void put(logic [2:0] kind, logic [7:0] ch);
      result_t r;
      r.kind = kind;
      r.ch   = (kind == TkSchar) ? ch : 8'h00;
      r.last = 1'b0;
      step_run.push_back(r);
    endfunction

    // a byte met with no string or comment open
    function void lex_between(logic [7:0] c);
      case (c)
        ChSpace, ChTab: mode = ModeBetween;
        ChSemi, ChHash: mode = ModeComment;
        ChNewline: begin
          mode = ModeBetween;
          put(TkNewline, 8'h00);
        end
        ChEqual: begin
          mode = ModeBetween;
          put(TkEqual, 8'h00);
        end
        ChLbrack: begin
          mode = ModeBetween;
          put(TkLbrack, 8'h00);
        end
        ChRbrack: begin
          mode = ModeBetween;
          put(TkRbrack, 8'h00);
        end
        ChQuote: begin
          mode = ModeQuoted;
          put(TkSbegin, 8'h00);
        end
        default: begin
          mode = ModeBare;
          put(TkSbegin, 8'h00);
          put(TkSchar, c);
        end
      endcase
    endfunction

    // predicts the tokens of one accepted transfer and returns how many there are
    function int note_input(logic [7:0] c, logic eoi);
      int n;
      step_run.delete();
      if (eoi) begin
        if (mode == ModeQuoted || mode == ModeBare) put(TkSend, 8'h00);
        put(TkEnd, 8'h00);
        mode = ModeBetween;
      end else begin
        case (mode)
          ModeComment: begin
            if (c == ChNewline) begin
              mode = ModeBetween;
              put(TkNewline, 8'h00);
            end
          end
          ModeQuoted: begin
            if (c == ChQuote || c == ChNewline) begin
              mode = ModeBetween;
              put(TkSend, 8'h00);
            end else begin
              put(TkSchar, c);
            end
          end
          ModeBare: begin
            // a terminator closes the string and is then lexed afresh
            case (c)
              ChNewline, ChEqual, ChLbrack, ChRbrack, ChQuote, ChSemi, ChHash: begin
                put(TkSend, 8'h00);
                lex_between(c);
              end
              default: put(TkSchar, c);
            endcase
          end
          default: lex_between(c);
        endcase
      end
      n = step_run.size();
      if (n > 0) step_run[n-1].last = 1'b1;
      foreach (step_run[i]) owed.push_back(step_run[i]);
      return n;
    endfunction

    // compares one accepted token with the oldest one owed
    function void check_token(logic [2:0] kind, logic [7:0] ch, logic last);
      result_t want;
      checked++;
      if (owed.size() == 0) begin
        $error("token with nothing owed: kind %0d char %02h last %0d", kind, ch, last);
        fails++;
        return;
      end
      want = owed.pop_front();
      if (kind !== want.kind) begin
        $error("token_kind: expected %0d, got %0d", want.kind, kind);
        fails++;
      end
      if (ch !== want.ch) begin
        $error("string_char: expected %02h, got %02h", want.ch, ch);
        fails++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0d, got %0d", want.last, last);
        fails++;
      end
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte     = 8'h00;
  logic        in_eoi      = 1'b0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [2:0]  token_kind;
  logic [7:0]  string_char;
  logic        last_of_run;
  logic        calm        = 1'b0;
  int unsigned cycles      = 0;
  int unsigned accepted    = 0;
  int unsigned end_marks   = 0;
  int unsigned productive  = 0;
  int unsigned hold_cnt    = 0;
  token_scoreboard board   = new();

  ini_stream_tokenizer dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .input_byte_i   (in_byte),
    .end_of_input_i (in_eoi),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .token_kind_o   (token_kind),
    .string_char_o  (string_char),
    .last_of_run_o  (last_of_run)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle length: mostly none, often short, now and then long
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  // characters for names and values, with the odd stray byte
  function automatic logic [7:0] name_char();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'($urandom_range(0, 255));
    if (r == 1) return ChSpace;
    if (r < 5) return 8'($urandom_range(8'h30, 8'h39));
    return 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  // one transfer on the input channel, then a random gap
  task automatic send_item(input logic [7:0] b, input logic e);
    int unsigned gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= b;
    in_eoi   <= e;
    do @(posedge clk); while (in_stall);
    accepted++;
    if (e) end_marks++;
    if (board.note_input(b, e) > 0) productive++;
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_word(input int unsigned n);
    repeat (n) send_item(name_char(), 1'b0);
  endtask

  // one line of ini text, mostly well formed, sometimes noise or cut short
  task automatic send_line();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    case (pick)
      0, 1: begin
        send_item(ChLbrack, 1'b0);
        send_word($urandom_range(1, 8));
        send_item(ChRbrack, 1'b0);
        send_item(ChNewline, 1'b0);
      end
      2, 3: begin
        send_item($urandom_range(0, 1) ? ChSemi : ChHash, 1'b0);
        send_word($urandom_range(0, 10));
        send_item(ChNewline, 1'b0);
      end
      4: send_item(ChNewline, 1'b0);
      5, 6: repeat ($urandom_range(1, 6)) send_item(8'($urandom_range(0, 255)), 1'b0);
      7: begin
        send_item(ChQuote, 1'b0);
        send_word($urandom_range(0, 6));
        send_item(ChNewline, 1'b0);
      end
      8: send_item(8'($urandom_range(0, 255)), 1'b1);
      default: begin
        send_word($urandom_range(1, 8));
        if ($urandom_range(0, 1)) send_item(ChSpace, 1'b0);
        send_item(ChEqual, 1'b0);
        if ($urandom_range(0, 1)) send_item($urandom_range(0, 1) ? ChSpace : ChTab, 1'b0);
        if ($urandom_range(0, 3) == 0) begin
          send_item(ChQuote, 1'b0);
          send_word($urandom_range(0, 6));
          send_item(ChQuote, 1'b0);
        end else if ($urandom_range(0, 4) != 0) begin
          send_word($urandom_range(1, 8));
        end
        if ($urandom_range(0, 3) == 0) begin
          send_item(ChSemi, 1'b0);
          send_word($urandom_range(0, 6));
        end
        send_item(ChNewline, 1'b0);
      end
    endcase
  endtask

  // token sink stall
  always @(negedge clk) begin
    int unsigned n;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else begin
      n = idle_gap();
      out_stall <= (n > 0);
      if (n > 0) hold_cnt <= n - 1;
    end
  end

  // check each token transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_token(token_kind, string_char, last_of_run);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles with %0d tokens owed", cycles, board.owed.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // stimulus
  initial begin
    int unsigned base;
    bit          held;
    held = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // end marks first, the second with a byte that must be ignored
    send_item(8'h00, 1'b1);
    send_item(8'hA5, 1'b1);
    // skipped blanks, brackets, zero byte in a bare string with blanks inside
    send_text(" \t[");
    send_item(8'h00, 1'b0);
    send_text(" \t]\n");
    // top byte value, bare string closed by equals, empty quoted string
    send_item(8'hFF, 1'b0);
    send_text("=\"\"\"");
    // quoted string closed by a newline
    send_item(8'h80, 1'b0);
    send_text("\n;=\n");
    // bare strings closed by hash, quote, open bracket, newline and semicolon
    send_text("k#\nv\";");
    send_item(8'h00, 1'b1);
    send_text("x[w\nq;\n");
    // end of input inside a bare string and inside a comment
    send_text("r");
    send_item(8'h00, 1'b1);
    send_text("#");
    send_item(8'h00, 1'b1);

    // random ini text
    base = accepted;
    while (accepted < base + RandomRuns) begin
      calm = (accepted >= base + 100 && accepted < base + 180);
      if (!held && accepted >= base + 300) begin
        // let the block drain completely before carrying on
        held = 1'b1;
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.owed.size() != 0) @(posedge clk);
      end
      send_line();
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered directed and random ini text: %0d transfers in, %0d of them end marks",
             accepted, end_marks);
    $display("%0d transfers gave tokens, %0d tokens checked, %0d field mismatches",
             productive, board.checked, board.fails);
    if (board.fails == 0 && board.owed.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== ini_stream_tokenizer.f =====
+incdir+rtl
rtl/ist_pkg.sv
rtl/ist_lexer_step.sv
rtl/ini_stream_tokenizer.sv
rtl/ist_checker.sv
bench/testbench.sv
